>>> hdl/pag_pkg.sv
// shared types and constants for the preferential attachment graph generator
// no dependencies; used by pag_mod_unit, pag_chosen_set and the top level
package pag_pkg;

  // default sizes of the vertex store and the per-vertex attachment list
  localparam int MAX_VERTICES_DEF = 256;
  localparam int MAX_ATTACH_DEF   = 16;

  // fixed field widths
  localparam int DRAW_W     = 31;
  localparam int VERT_OUT_W = 8;
  localparam int ATTACH_W   = 5;
  localparam int SEED_W     = 9;
  localparam int TOTAL_W    = 9;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ATTACH = 2'd0;
  localparam logic [1:0] REG_SEED   = 2'd1;
  localparam logic [1:0] REG_TOTAL  = 2'd2;

  // register reset values
  localparam logic [ATTACH_W-1:0] ATTACH_RST = 5'd2;
  localparam logic [SEED_W-1:0]   SEED_RST   = 9'd3;
  localparam logic [TOTAL_W-1:0]  TOTAL_RST  = 9'd16;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_CLIQUE = 2'd1,
    PH_ATTACH = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_MOD,
    S_WALK,
    S_RD_PICK,
    S_WR_PICK,
    S_WR_NEW,
    S_EMIT
  } seq_state_t;

  // commands to the chosen-vertex list
  typedef struct packed {
    logic clear;
    logic push;
  } chosen_cmd_t;

endpackage

>>> hdl/pag_mod_unit.sv
// iterative remainder unit: one restoring step per cycle over the draw bits
// depends on pag_pkg
module pag_mod_unit #(
  parameter int TW = 17
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pag_pkg::DRAW_W-1:0] dividend,
  input  logic [TW-1:0]             divisor,
  output logic                      done,
  output logic [TW-1:0]             remainder
);

  localparam int CNT_W = $clog2(pag_pkg::DRAW_W + 1);

  logic                       run;
  logic [CNT_W-1:0]           cnt;
  logic [pag_pkg::DRAW_W-1:0] quo;
  logic [TW-1:0]              div;
  logic [TW-1:0]              rem;
  logic [TW:0]                trial;
  logic                       fits;

  assign trial = {rem, quo[pag_pkg::DRAW_W-1]};
  assign fits  = trial >= {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(pag_pkg::DRAW_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      div <= divisor;
    end else if (run) begin
      quo <= {quo[pag_pkg::DRAW_W-2:0], 1'b0};
      if (fits) begin
        rem <= TW'(trial - {1'b0, div});
      end else begin
        rem <= TW'(trial);
      end
    end
  end

  // empty range gives a zero draw
  assign remainder = (div == '0) ? '0 : rem;

endmodule

>>> hdl/pag_chosen_set.sv
// list of vertices already chosen for the current new vertex, with a membership probe
// depends on pag_pkg
module pag_chosen_set #(
  parameter int MAX_ATTACH = pag_pkg::MAX_ATTACH_DEF,
  parameter int IW         = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pag_pkg::chosen_cmd_t               cmd,
  input  logic [IW-1:0]                      push_vertex,
  input  logic [IW-1:0]                      probe_vertex,
  output logic                               hit,
  output logic [$clog2(MAX_ATTACH+1)-1:0]    count
);

  localparam int CW  = $clog2(MAX_ATTACH + 1);
  localparam int AIW = (MAX_ATTACH > 1) ? $clog2(MAX_ATTACH) : 1;

  logic [IW-1:0] list [MAX_ATTACH];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      list[AIW'(count)] <= push_vertex;
    end
  end

  // parallel compare against every filled slot
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < MAX_ATTACH; i++) begin
      if ((CW'(i) < count) && (list[i] == probe_vertex)) begin
        hit = 1'b1;
      end
    end
  end

endmodule

>>> hdl/preferential_attachment_graph_gen.sv
// top level of the preferential attachment graph generator
// depends on pag_pkg, pag_mod_unit and pag_chosen_set
//
// usage:
//   command channel: a transaction is taken when start is high and busy is low;
//   kind 0 restarts generation, kind 1 asks for the next edge, random_value is
//   the draw used when that edge is an attachment
//   result channel: every transaction gives exactly one result, shown for one
//   cycle with result_valid high; edge_valid, source_vertex, target_vertex and
//   done_res are only meaningful in that cycle; the receiver cannot stall
//   config: apb-style port, attach_count at 0x0, seed_size at 0x4,
//   vertex_total at 0x8; values are clamped and take effect at the next restart
//   busy states per transaction, the last one being the result strobe:
//     restart        degree store loaded with the clamped seed, one entry a cycle
//     clique / idle / done  result strobe only
//     attachment     the remainder unit (31 restoring steps, then done), then a walk
//                    over the vertices with one degree-store read a cycle, then
//                    read, write, a new-vertex write after the last attachment
//                    of the vertex, and the strobe
//   throughput: one transaction at a time, the next one is taken after the strobe
//   reset: no graph in progress, advance requests answer with no edge until a
//   restart; the degree store holds garbage until a restart fills it
module preferential_attachment_graph_gen #(
  parameter int MAX_VERTICES = pag_pkg::MAX_VERTICES_DEF,
  parameter int MAX_ATTACH   = pag_pkg::MAX_ATTACH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  logic                             kind,
  input  logic [pag_pkg::DRAW_W-1:0]       random_value,
  // result channel
  output logic                             result_valid,
  output logic                             edge_valid,
  output logic [pag_pkg::VERT_OUT_W-1:0]   source_vertex,
  output logic [pag_pkg::VERT_OUT_W-1:0]   target_vertex,
  output logic                             done_res,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pag_pkg::PADDR_W-1:0]      paddr,
  input  logic [pag_pkg::PDATA_W-1:0]      pwdata,
  output logic [pag_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int IW = $clog2(MAX_VERTICES);   // vertex index
  localparam int VW = IW + 1;                 // vertex count
  localparam int DW = IW + 1;                 // one degree
  localparam int TW = 2 * IW + 1;             // degree sums
  localparam int CW = $clog2(MAX_ATTACH + 1); // attachment count

  // ---------------------------------------------------------------- config
  logic [pag_pkg::ATTACH_W-1:0] attach_count;
  logic [pag_pkg::SEED_W-1:0]   seed_size;
  logic [pag_pkg::TOTAL_W-1:0]  vertex_total;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      attach_count <= pag_pkg::ATTACH_RST;
      seed_size    <= pag_pkg::SEED_RST;
      vertex_total <= pag_pkg::TOTAL_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        pag_pkg::REG_ATTACH: attach_count <= pwdata[pag_pkg::ATTACH_W-1:0];
        pag_pkg::REG_SEED:   seed_size    <= pwdata[pag_pkg::SEED_W-1:0];
        pag_pkg::REG_TOTAL:  vertex_total <= pwdata[pag_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pag_pkg::REG_ATTACH: prdata = pag_pkg::PDATA_W'(attach_count);
      pag_pkg::REG_SEED:   prdata = pag_pkg::PDATA_W'(seed_size);
      pag_pkg::REG_TOTAL:  prdata = pag_pkg::PDATA_W'(vertex_total);
      default:             prdata = '0;
    endcase
  end

  // clamped settings, latched at restart
  logic [31:0] s_c, t_c, a_c, lim_c;

  always_comb begin
    s_c = 32'(seed_size);
    if (s_c < 32'd2) s_c = 32'd2;
    if (s_c > 32'(MAX_VERTICES)) s_c = 32'(MAX_VERTICES);
    t_c = 32'(vertex_total);
    if (t_c < s_c) t_c = s_c;
    if (t_c > 32'(MAX_VERTICES)) t_c = 32'(MAX_VERTICES);
    lim_c = (32'(MAX_ATTACH) < s_c) ? 32'(MAX_ATTACH) : s_c;
    a_c = 32'(attach_count);
    if (a_c < 32'd1) a_c = 32'd1;
    if (a_c > lim_c) a_c = lim_c;
  end

  // ---------------------------------------------------------------- state
  pag_pkg::seq_state_t state, state_next;
  pag_pkg::phase_t     phase;

  logic [VW-1:0] lat_seed;
  logic [VW-1:0] lat_total;
  logic [CW-1:0] lat_attach;

  logic [TW-1:0] degree_total;
  logic [TW-1:0] chosen_degree_total;
  logic [VW-1:0] current_vertex;
  logic [VW-1:0] clique_row;
  logic [VW-1:0] clique_col;
  logic [VW-1:0] fill_idx;

  // walk pipeline: degree checked in the cycle after its address is issued
  logic [VW-1:0] walk_k;
  logic          p_vld;
  logic [IW-1:0] p_k;
  logic [TW-1:0] walk_sum;
  logic [TW-1:0] walk_sum_add;
  logic          first_vld;
  logic [IW-1:0] first_k;
  logic [IW-1:0] pick;
  logic [TW-1:0] draw_mod;

  logic          accept;
  logic          fill_last;
  logic          walk_found;
  logic          walk_empty;
  logic          attach_last;
  logic [DW-1:0] pick_deg;
  logic [CW-1:0] chosen_next;

  // result registers
  logic                           res_edge;
  logic [pag_pkg::VERT_OUT_W-1:0] res_src;
  logic [pag_pkg::VERT_OUT_W-1:0] res_dst;
  logic                           res_done;

  // degree store
  logic [DW-1:0] deg_mem [MAX_VERTICES];
  logic [DW-1:0] rdata;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;

  // remainder unit and chosen-vertex list
  logic                 mod_start;
  logic                 mod_done;
  logic [TW-1:0]        mod_rem;
  pag_pkg::chosen_cmd_t chosen_cmd;
  logic                 chosen_hit;
  logic [CW-1:0]        chosen_count;

  pag_mod_unit #(
    .TW (TW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (random_value),
    .divisor   (degree_total - chosen_degree_total),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  pag_chosen_set #(
    .MAX_ATTACH (MAX_ATTACH),
    .IW         (IW)
  ) u_chosen (
    .clk          (clk),
    .rst          (rst),
    .cmd          (chosen_cmd),
    .push_vertex  (pick),
    .probe_vertex (p_k),
    .hit          (chosen_hit),
    .count        (chosen_count)
  );

  assign accept       = start && (state == pag_pkg::S_IDLE);
  assign busy         = (state != pag_pkg::S_IDLE);
  assign fill_last    = (fill_idx + 1'b1) >= lat_seed;
  assign walk_sum_add = walk_sum + TW'(rdata);
  assign walk_found   = p_vld && !chosen_hit && (walk_sum_add > draw_mod);
  assign walk_empty   = !p_vld && (walk_k >= current_vertex);
  assign pick_deg     = rdata + 1'b1;
  assign chosen_next  = chosen_count + 1'b1;
  assign attach_last  = chosen_next >= lat_attach;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      pag_pkg::S_IDLE: begin
        if (accept) begin
          if (!kind) begin
            state_next = pag_pkg::S_FILL;
          end else if (phase == pag_pkg::PH_ATTACH) begin
            state_next = pag_pkg::S_MOD;
          end else begin
            state_next = pag_pkg::S_EMIT;
          end
        end
      end
      pag_pkg::S_FILL:    if (fill_last) state_next = pag_pkg::S_EMIT;
      pag_pkg::S_MOD:     if (mod_done) state_next = pag_pkg::S_WALK;
      pag_pkg::S_WALK:    if (walk_found || walk_empty) state_next = pag_pkg::S_RD_PICK;
      pag_pkg::S_RD_PICK: state_next = pag_pkg::S_WR_PICK;
      pag_pkg::S_WR_PICK: begin
        state_next = attach_last ? pag_pkg::S_WR_NEW : pag_pkg::S_EMIT;
      end
      pag_pkg::S_WR_NEW:  state_next = pag_pkg::S_EMIT;
      pag_pkg::S_EMIT:    state_next = pag_pkg::S_IDLE;
      default:            state_next = pag_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  always_comb begin
    mod_start  = 1'b0;
    chosen_cmd = '0;
    mem_we     = 1'b0;
    mem_waddr  = pick;
    mem_wdata  = pick_deg;
    rd_addr    = walk_k[IW-1:0];
    case (state)
      pag_pkg::S_IDLE: begin
        mod_start        = accept && kind && (phase == pag_pkg::PH_ATTACH);
        chosen_cmd.clear = accept && !kind;
      end
      pag_pkg::S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_idx[IW-1:0];
        mem_wdata = DW'(lat_seed - 1'b1);
      end
      pag_pkg::S_RD_PICK: rd_addr = pick;
      pag_pkg::S_WR_PICK: begin
        mem_we          = 1'b1;
        chosen_cmd.push = 1'b1;
      end
      pag_pkg::S_WR_NEW: begin
        mem_we           = 1'b1;
        mem_waddr        = current_vertex[IW-1:0];
        mem_wdata        = DW'(lat_attach);
        chosen_cmd.clear = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- degree store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      deg_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= deg_mem[rd_addr];
  end

  // ---------------------------------------------------------------- sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= pag_pkg::S_IDLE;
      phase               <= pag_pkg::PH_IDLE;
      lat_seed            <= VW'(3);
      lat_total           <= VW'(16);
      lat_attach          <= CW'(2);
      degree_total        <= '0;
      chosen_degree_total <= '0;
      current_vertex      <= '0;
      clique_row          <= '0;
      clique_col          <= VW'(1);
      fill_idx            <= '0;
      p_vld               <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        pag_pkg::S_IDLE: begin
          if (accept) begin
            if (!kind) begin
              // restart: latch clamped settings, then load the seed degrees
              lat_seed            <= VW'(s_c);
              lat_total           <= VW'(t_c);
              lat_attach          <= CW'(a_c);
              degree_total        <= '0;
              chosen_degree_total <= '0;
              current_vertex      <= VW'(s_c);
              clique_row          <= '0;
              clique_col          <= VW'(1);
              fill_idx            <= '0;
            end else if (phase == pag_pkg::PH_CLIQUE) begin
              // next clique edge in row-major order
              if ((clique_col + 1'b1) >= lat_seed) begin
                clique_row <= clique_row + 1'b1;
                clique_col <= clique_row + VW'(2);
                if ((clique_row + VW'(2)) >= lat_seed) begin
                  phase <= (current_vertex >= lat_total) ? pag_pkg::PH_DONE
                                                         : pag_pkg::PH_ATTACH;
                end
              end else begin
                clique_col <= clique_col + 1'b1;
              end
            end
          end
          p_vld <= 1'b0;
        end
        pag_pkg::S_FILL: begin
          degree_total <= degree_total + TW'(lat_seed - 1'b1);
          fill_idx     <= fill_idx + 1'b1;
          if (fill_last) begin
            phase <= pag_pkg::PH_CLIQUE;
          end
        end
        pag_pkg::S_MOD: begin
          p_vld <= 1'b0;
        end
        pag_pkg::S_WALK: begin
          p_vld <= walk_k < current_vertex;
        end
        pag_pkg::S_WR_PICK: begin
          degree_total        <= degree_total + 1'b1;
          chosen_degree_total <= chosen_degree_total + TW'(pick_deg);
        end
        pag_pkg::S_WR_NEW: begin
          degree_total        <= degree_total + TW'(lat_attach);
          chosen_degree_total <= '0;
          current_vertex      <= current_vertex + 1'b1;
          if ((current_vertex + 1'b1) >= lat_total) begin
            phase <= pag_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // walk datapath and result payload
  always_ff @(posedge clk) begin
    case (state)
      pag_pkg::S_IDLE: begin
        res_edge <= 1'b0;
        res_src  <= '0;
        res_dst  <= '0;
        res_done <= 1'b0;
        if (accept && kind) begin
          if (phase == pag_pkg::PH_CLIQUE) begin
            res_edge <= 1'b1;
            res_src  <= pag_pkg::VERT_OUT_W'(clique_row);
            res_dst  <= pag_pkg::VERT_OUT_W'(clique_col);
            res_done <= ((clique_col + 1'b1) >= lat_seed)
                        && ((clique_row + VW'(2)) >= lat_seed)
                        && (current_vertex >= lat_total);
          end else if (phase == pag_pkg::PH_DONE) begin
            res_done <= 1'b1;
          end
        end
        walk_k    <= '0;
        walk_sum  <= '0;
        first_vld <= 1'b0;
      end
      pag_pkg::S_MOD: begin
        if (mod_done) begin
          draw_mod <= mod_rem;
        end
      end
      pag_pkg::S_WALK: begin
        if (walk_k < current_vertex) begin
          p_k    <= walk_k[IW-1:0];
          walk_k <= walk_k + 1'b1;
        end
        if (p_vld && !chosen_hit) begin
          walk_sum <= walk_sum_add;
          if (!first_vld) begin
            first_vld <= 1'b1;
            first_k   <= p_k;
          end
        end
        if (walk_found) begin
          pick <= p_k;
        end else if (walk_empty) begin
          // no vertex reached the draw: fall back to the first unchosen one
          pick <= first_vld ? first_k : '0;
        end
      end
      pag_pkg::S_WR_PICK: begin
        res_edge <= 1'b1;
        res_src  <= pag_pkg::VERT_OUT_W'(current_vertex);
        res_dst  <= pag_pkg::VERT_OUT_W'(pick);
        res_done <= 1'b0;
      end
      pag_pkg::S_WR_NEW: begin
        res_done <= (current_vertex + 1'b1) >= lat_total;
      end
      default: ;
    endcase
  end

  assign result_valid  = (state == pag_pkg::S_EMIT);
  assign edge_valid    = res_edge;
  assign source_vertex = res_src;
  assign target_vertex = res_dst;
  assign done_res      = res_done;

endmodule
